// File: hdl/triangle_barycentric_weights_assert.svh
// Assertion macros used by the block's top-level RTL file.
`ifndef TRIANGLE_BARYCENTRIC_WEIGHTS_ASSERT_SVH
`define TRIANGLE_BARYCENTRIC_WEIGHTS_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define TBW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define TBW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define TBW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TBW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/tbw_pkg.sv
package tbw_pkg;

    // Coordinate format
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int THR_WIDTH   = 40;

    // Derived datapath widths
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int MAG_W   = 2 * COORD_WIDTH + 1;
    localparam int SPLIT_W = COORD_WIDTH + 1;
    localparam int HI_W    = MAG_W - SPLIT_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int TL_W    = THR_WIDTH + MAG_W;
    localparam int CMP_W   = SQ_W + THR_WIDTH;
    localparam int NUM_W   = MAG_W + FRAC_BITS;
    localparam int REM_W   = NUM_W + COORD_WIDTH;
    localparam int Q_W     = COORD_WIDTH - 1;

    // Pipeline depth
    localparam int DIV_STAGES   = COORD_WIDTH;
    localparam int FRONT_STAGES = 10;
    localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic [MAG_W-1:0]              mag_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic [Q_W-1:0] quot;
        logic           ovf;
        logic           neg;
    } div_res_t;

    typedef struct packed {
        coord_t weight_a;
        coord_t weight_b;
        coord_t weight_c;
        axis_t  axis;
        logic   degenerate;
    } result_t;

endpackage

// File: hdl/tbw_div.sv
module tbw_div
    import tbw_pkg::*;
(
    input  logic             aclk,
    input  logic             adv,
    input  logic [NUM_W-1:0] num,
    input  mag_t             den,
    input  logic             neg,
    output div_res_t         res
);

    logic [REM_W-1:0]      rem_reg  [DIV_STAGES];
    mag_t                  den_reg  [DIV_STAGES];
    logic [Q_W-1:0]        quot_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] ovf_reg;
    logic [DIV_STAGES-1:0] neg_reg;
    logic [REM_W-1:0]      lim;
    logic [REM_W-1:0]      trial [1:DIV_STAGES-1];
    logic [DIV_STAGES-1:1] take;

    // quotient at or above the sign bit saturates
    assign lim = REM_W'(den) << Q_W;

    // trial subtract per stage, one quotient bit each
    always_comb begin
        for (int k = 1; k < DIV_STAGES; k++) begin
            trial[k] = REM_W'(den_reg[k-1]) << (DIV_STAGES - 1 - k);
            take[k]  = rem_reg[k-1] >= trial[k];
        end
    end

    // advance the restoring division one bit per stage
    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= REM_W'(num);
            den_reg[0]  <= den;
            quot_reg[0] <= '0;
            ovf_reg[0]  <= REM_W'(num) >= lim;
            neg_reg[0]  <= neg;
            for (int k = 1; k < DIV_STAGES; k++) begin
                rem_reg[k]  <= take[k] ? rem_reg[k-1] - trial[k] : rem_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                quot_reg[k] <= quot_reg[k-1] | (Q_W'(take[k]) << (DIV_STAGES - 1 - k));
                ovf_reg[k]  <= ovf_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
            end
        end
    end

    assign res.quot = quot_reg[DIV_STAGES-1];
    assign res.ovf  = ovf_reg[DIV_STAGES-1];
    assign res.neg  = neg_reg[DIV_STAGES-1];

endmodule

// File: hdl/triangle_barycentric_weights.sv
// The accepting edge loads the first of 10 front stages; the item then passes
// 32 bit-per-stage divider stages, which set the depth, and one output register.
// Throughput: one item per cycle while no item waits in the skid register.
// An output skid register lets one more item in after the result side stalls.
// Reset (aresetn low, synchronous) clears all valid bits and the threshold.
`include "triangle_barycentric_weights_assert.svh"

module triangle_barycentric_weights
    import tbw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [THR_WIDTH-1:0]  cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  coord_t                s_vertex_a_x,
    input  coord_t                s_vertex_a_y,
    input  coord_t                s_vertex_a_z,
    input  coord_t                s_vertex_b_x,
    input  coord_t                s_vertex_b_y,
    input  coord_t                s_vertex_b_z,
    input  coord_t                s_vertex_c_x,
    input  coord_t                s_vertex_c_y,
    input  coord_t                s_vertex_c_z,
    input  coord_t                s_point_x,
    input  coord_t                s_point_y,
    input  coord_t                s_point_z,
    output logic                  m_valid,
    input  logic                  m_ready,
    output coord_t                m_weight_a,
    output coord_t                m_weight_b,
    output coord_t                m_weight_c,
    output logic [1:0]            m_dropped_axis,
    output logic                  m_degenerate
);

    localparam int SUM_W = COORD_WIDTH + 2;
    typedef logic signed [SUM_W-1:0] sum_t;
    localparam coord_t W_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t W_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam sum_t   W_ONE = sum_t'(1 <<< FRAC_BITS);

    // control
    logic                  adv;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  out_vld_reg;
    logic                  skid_vld_reg;
    logic [THR_WIDTH-1:0]  thr_reg;

    // input view
    coord_t in_v [3][3];
    coord_t in_p [3];

    // stage 1: edge vectors
    coord_t v_s1_reg [3][3];
    coord_t p_s1_reg [3];
    diff_t  ab_s1_reg [3];
    diff_t  cb_s1_reg [3];
    // stage 2: normal products
    coord_t v_s2_reg [3][3];
    coord_t p_s2_reg [3];
    prod_t  np_s2_reg [3];
    prod_t  nq_s2_reg [3];
    // stage 3: normal magnitudes
    coord_t v_s3_reg [3][3];
    coord_t p_s3_reg [3];
    mag_t   an_s3_reg [3];
    prod_t  n_c [3];
    // stage 4: projection
    axis_t  ax_c;
    mag_t   an_best;
    coord_t u_c [3];
    coord_t w_c [3];
    coord_t pu_c;
    coord_t pw_c;
    axis_t  ax_s4_reg;
    coord_t u_s4_reg [3];
    coord_t w_s4_reg [3];
    coord_t pu_s4_reg;
    coord_t pw_s4_reg;
    // stage 5: projected differences
    axis_t  ax_s5_reg;
    diff_t  du10_s5_reg, dw10_s5_reg, du21_s5_reg, dw21_s5_reg;
    diff_t  du02_s5_reg, dw02_s5_reg;
    diff_t  dpu1_s5_reg, dpw1_s5_reg, dpu2_s5_reg, dpw2_s5_reg;
    // stage 6: products
    axis_t  ax_s6_reg;
    prod_t  pd0_s6_reg, pd1_s6_reg;
    prod_t  l1a_s6_reg, l1b_s6_reg, l2a_s6_reg, l2b_s6_reg;
    prod_t  xa0_s6_reg, xa1_s6_reg, xb0_s6_reg, xb1_s6_reg;
    // stage 7: cross products and squared lengths
    axis_t  ax_s7_reg;
    prod_t  d_s7_reg, xa_s7_reg, xb_s7_reg;
    mag_t   l1_s7_reg, l2_s7_reg;
    // stage 8: magnitudes and signs
    axis_t  ax_s8_reg;
    mag_t   dmag_s8_reg, xam_s8_reg, xbm_s8_reg, l1_s8_reg, l2_s8_reg;
    logic   nega_s8_reg, negb_s8_reg, lflag_s8_reg;
    // stage 9: partial products
    axis_t  ax_s9_reg;
    mag_t   dmag_s9_reg, xam_s9_reg, xbm_s9_reg;
    logic   nega_s9_reg, negb_s9_reg, lflag_s9_reg;
    logic [2*HI_W-1:0]            dhh_s9_reg;
    logic [HI_W+SPLIT_W-1:0]      dhl_s9_reg;
    logic [2*SPLIT_W-1:0]         dll_s9_reg;
    logic [THR_WIDTH+HI_W-1:0]    t1h_s9_reg, t2h_s9_reg;
    logic [THR_WIDTH+SPLIT_W-1:0] t1l_s9_reg, t2l_s9_reg;
    // stage 10: full square and threshold-length products
    axis_t  ax_s10_reg;
    mag_t   dmag_s10_reg, xam_s10_reg, xbm_s10_reg;
    logic   nega_s10_reg, negb_s10_reg, lflag_s10_reg;
    logic [SQ_W-1:0] d2_s10_reg;
    logic [TL_W-1:0] tl1_s10_reg, tl2_s10_reg;
    // side data along the divider stages
    axis_t  ax_side_reg  [DIV_STAGES];
    logic [DIV_STAGES-1:0] deg_side_reg;
    logic   deg_c;
    // output
    div_res_t res_a, res_b;
    coord_t   wa_c, wb_c;
    sum_t     wc_sum;
    result_t  res_next;
    result_t  out_reg;
    result_t  skid_reg;
    result_t  m_res;

    // configuration and handshake
    assign cfg_ready = 1'b1;
    assign adv       = !skid_vld_reg;
    assign s_ready   = adv;

    always_comb begin
        in_v[0][0] = s_vertex_a_x;
        in_v[0][1] = s_vertex_a_y;
        in_v[0][2] = s_vertex_a_z;
        in_v[1][0] = s_vertex_b_x;
        in_v[1][1] = s_vertex_b_y;
        in_v[1][2] = s_vertex_b_z;
        in_v[2][0] = s_vertex_c_x;
        in_v[2][1] = s_vertex_c_y;
        in_v[2][2] = s_vertex_c_z;
        in_p[0]    = s_point_x;
        in_p[1]    = s_point_y;
        in_p[2]    = s_point_z;
    end

    // normal components from the stage 2 products
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_c[j] = np_s2_reg[j] - nq_s2_reg[j];
        end
    end

    // pick the dominant axis and project onto the other two
    always_comb begin
        ax_c    = AXIS_X;
        an_best = an_s3_reg[0];
        if (an_s3_reg[1] > an_s3_reg[0]) begin
            ax_c    = AXIS_Y;
            an_best = an_s3_reg[1];
        end
        if (an_s3_reg[2] > an_best) begin
            ax_c = AXIS_Z;
        end
        unique case (ax_c)
            AXIS_Y: begin
                for (int i = 0; i < 3; i++) begin
                    u_c[i] = v_s3_reg[i][2];
                    w_c[i] = v_s3_reg[i][0];
                end
                pu_c = p_s3_reg[2];
                pw_c = p_s3_reg[0];
            end
            AXIS_Z: begin
                for (int i = 0; i < 3; i++) begin
                    u_c[i] = v_s3_reg[i][0];
                    w_c[i] = v_s3_reg[i][1];
                end
                pu_c = p_s3_reg[0];
                pw_c = p_s3_reg[1];
            end
            default: begin
                for (int i = 0; i < 3; i++) begin
                    u_c[i] = v_s3_reg[i][1];
                    w_c[i] = v_s3_reg[i][2];
                end
                pu_c = p_s3_reg[1];
                pw_c = p_s3_reg[2];
            end
        endcase
    end

    // front pipeline payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 1
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    v_s1_reg[i][j] <= in_v[i][j];
                end
                p_s1_reg[j]  <= in_p[j];
                ab_s1_reg[j] <= diff_t'(in_v[0][j]) - diff_t'(in_v[1][j]);
                cb_s1_reg[j] <= diff_t'(in_v[2][j]) - diff_t'(in_v[1][j]);
            end
            // stage 2
            v_s2_reg     <= v_s1_reg;
            p_s2_reg     <= p_s1_reg;
            np_s2_reg[0] <= ab_s1_reg[1] * cb_s1_reg[2];
            nq_s2_reg[0] <= ab_s1_reg[2] * cb_s1_reg[1];
            np_s2_reg[1] <= ab_s1_reg[2] * cb_s1_reg[0];
            nq_s2_reg[1] <= ab_s1_reg[0] * cb_s1_reg[2];
            np_s2_reg[2] <= ab_s1_reg[0] * cb_s1_reg[1];
            nq_s2_reg[2] <= ab_s1_reg[1] * cb_s1_reg[0];
            // stage 3
            v_s3_reg <= v_s2_reg;
            p_s3_reg <= p_s2_reg;
            for (int j = 0; j < 3; j++) begin
                an_s3_reg[j] <= mag_t'(n_c[j][PROD_W-1] ? -n_c[j] : n_c[j]);
            end
            // stage 4
            ax_s4_reg <= ax_c;
            u_s4_reg  <= u_c;
            w_s4_reg  <= w_c;
            pu_s4_reg <= pu_c;
            pw_s4_reg <= pw_c;
            // stage 5
            ax_s5_reg   <= ax_s4_reg;
            du10_s5_reg <= diff_t'(u_s4_reg[0]) - diff_t'(u_s4_reg[1]);
            dw10_s5_reg <= diff_t'(w_s4_reg[0]) - diff_t'(w_s4_reg[1]);
            du21_s5_reg <= diff_t'(u_s4_reg[2]) - diff_t'(u_s4_reg[1]);
            dw21_s5_reg <= diff_t'(w_s4_reg[2]) - diff_t'(w_s4_reg[1]);
            du02_s5_reg <= diff_t'(u_s4_reg[0]) - diff_t'(u_s4_reg[2]);
            dw02_s5_reg <= diff_t'(w_s4_reg[0]) - diff_t'(w_s4_reg[2]);
            dpu1_s5_reg <= diff_t'(pu_s4_reg) - diff_t'(u_s4_reg[1]);
            dpw1_s5_reg <= diff_t'(pw_s4_reg) - diff_t'(w_s4_reg[1]);
            dpu2_s5_reg <= diff_t'(pu_s4_reg) - diff_t'(u_s4_reg[2]);
            dpw2_s5_reg <= diff_t'(pw_s4_reg) - diff_t'(w_s4_reg[2]);
            // stage 6
            ax_s6_reg  <= ax_s5_reg;
            pd0_s6_reg <= du10_s5_reg * dw21_s5_reg;
            pd1_s6_reg <= dw10_s5_reg * du21_s5_reg;
            l1a_s6_reg <= du21_s5_reg * du21_s5_reg;
            l1b_s6_reg <= dw21_s5_reg * dw21_s5_reg;
            l2a_s6_reg <= du02_s5_reg * du02_s5_reg;
            l2b_s6_reg <= dw02_s5_reg * dw02_s5_reg;
            xa0_s6_reg <= dpu1_s5_reg * dw21_s5_reg;
            xa1_s6_reg <= dpw1_s5_reg * du21_s5_reg;
            xb0_s6_reg <= dpu2_s5_reg * dw02_s5_reg;
            xb1_s6_reg <= dpw2_s5_reg * du02_s5_reg;
            // stage 7
            ax_s7_reg <= ax_s6_reg;
            d_s7_reg  <= pd0_s6_reg - pd1_s6_reg;
            xa_s7_reg <= xa0_s6_reg - xa1_s6_reg;
            xb_s7_reg <= xb0_s6_reg - xb1_s6_reg;
            l1_s7_reg <= mag_t'(l1a_s6_reg) + mag_t'(l1b_s6_reg);
            l2_s7_reg <= mag_t'(l2a_s6_reg) + mag_t'(l2b_s6_reg);
            // stage 8
            ax_s8_reg    <= ax_s7_reg;
            dmag_s8_reg  <= mag_t'(d_s7_reg[PROD_W-1] ? -d_s7_reg : d_s7_reg);
            xam_s8_reg   <= mag_t'(xa_s7_reg[PROD_W-1] ? -xa_s7_reg : xa_s7_reg);
            xbm_s8_reg   <= mag_t'(xb_s7_reg[PROD_W-1] ? -xb_s7_reg : xb_s7_reg);
            nega_s8_reg  <= xa_s7_reg[PROD_W-1] != d_s7_reg[PROD_W-1];
            negb_s8_reg  <= xb_s7_reg[PROD_W-1] != d_s7_reg[PROD_W-1];
            l1_s8_reg    <= l1_s7_reg;
            l2_s8_reg    <= l2_s7_reg;
            lflag_s8_reg <= (TL_W'(l1_s7_reg) <= TL_W'(thr_reg))
                         || (TL_W'(l2_s7_reg) <= TL_W'(thr_reg));
            // stage 9
            ax_s9_reg    <= ax_s8_reg;
            dmag_s9_reg  <= dmag_s8_reg;
            xam_s9_reg   <= xam_s8_reg;
            xbm_s9_reg   <= xbm_s8_reg;
            nega_s9_reg  <= nega_s8_reg;
            negb_s9_reg  <= negb_s8_reg;
            lflag_s9_reg <= lflag_s8_reg;
            dhh_s9_reg   <= dmag_s8_reg[MAG_W-1:SPLIT_W] * dmag_s8_reg[MAG_W-1:SPLIT_W];
            dhl_s9_reg   <= dmag_s8_reg[MAG_W-1:SPLIT_W] * dmag_s8_reg[SPLIT_W-1:0];
            dll_s9_reg   <= dmag_s8_reg[SPLIT_W-1:0] * dmag_s8_reg[SPLIT_W-1:0];
            t1h_s9_reg   <= thr_reg * l1_s8_reg[MAG_W-1:SPLIT_W];
            t1l_s9_reg   <= thr_reg * l1_s8_reg[SPLIT_W-1:0];
            t2h_s9_reg   <= thr_reg * l2_s8_reg[MAG_W-1:SPLIT_W];
            t2l_s9_reg   <= thr_reg * l2_s8_reg[SPLIT_W-1:0];
            // stage 10
            ax_s10_reg    <= ax_s9_reg;
            dmag_s10_reg  <= dmag_s9_reg;
            xam_s10_reg   <= xam_s9_reg;
            xbm_s10_reg   <= xbm_s9_reg;
            nega_s10_reg  <= nega_s9_reg;
            negb_s10_reg  <= negb_s9_reg;
            lflag_s10_reg <= lflag_s9_reg;
            d2_s10_reg    <= (SQ_W'(dhh_s9_reg) << (2 * SPLIT_W))
                           + (SQ_W'(dhl_s9_reg) << (SPLIT_W + 1))
                           + SQ_W'(dll_s9_reg);
            tl1_s10_reg   <= (TL_W'(t1h_s9_reg) << SPLIT_W) + TL_W'(t1l_s9_reg);
            tl2_s10_reg   <= (TL_W'(t2h_s9_reg) << SPLIT_W) + TL_W'(t2l_s9_reg);
        end
    end

    // degenerate when an edge or perpendicular squared length is at or below threshold
    assign deg_c = lflag_s10_reg
                || (CMP_W'(d2_s10_reg) <= CMP_W'(tl1_s10_reg))
                || (CMP_W'(d2_s10_reg) <= CMP_W'(tl2_s10_reg));

    // carry axis and flag alongside the dividers
    always_ff @(posedge aclk) begin
        if (adv) begin
            ax_side_reg[0]  <= ax_s10_reg;
            deg_side_reg[0] <= deg_c;
            for (int k = 1; k < DIV_STAGES; k++) begin
                ax_side_reg[k]  <= ax_side_reg[k-1];
                deg_side_reg[k] <= deg_side_reg[k-1];
            end
        end
    end

    tbw_div u_div_a (
        .aclk (aclk),
        .adv  (adv),
        .num  (NUM_W'(xam_s10_reg) << FRAC_BITS),
        .den  (dmag_s10_reg),
        .neg  (nega_s10_reg),
        .res  (res_a)
    );

    tbw_div u_div_b (
        .aclk (aclk),
        .adv  (adv),
        .num  (NUM_W'(xbm_s10_reg) << FRAC_BITS),
        .den  (dmag_s10_reg),
        .neg  (negb_s10_reg),
        .res  (res_b)
    );

    // signed, saturated weight from a divider result
    function automatic coord_t apply_sign(div_res_t r);
        coord_t mag;
        mag = coord_t'(r.quot);
        if (r.ovf) begin
            return r.neg ? W_MIN : W_MAX;
        end
        return r.neg ? -mag : mag;
    endfunction

    // final weights, third one from the sum
    always_comb begin
        wa_c   = apply_sign(res_a);
        wb_c   = apply_sign(res_b);
        wc_sum = W_ONE - sum_t'(wa_c) - sum_t'(wb_c);
        res_next.axis       = ax_side_reg[DIV_STAGES-1];
        res_next.degenerate = deg_side_reg[DIV_STAGES-1];
        if (deg_side_reg[DIV_STAGES-1]) begin
            res_next.weight_a = '0;
            res_next.weight_b = '0;
            res_next.weight_c = '0;
        end else begin
            res_next.weight_a = wa_c;
            res_next.weight_b = wb_c;
            if (wc_sum > sum_t'(W_MAX)) begin
                res_next.weight_c = W_MAX;
            end else if (wc_sum < sum_t'(W_MIN)) begin
                res_next.weight_c = W_MIN;
            end else begin
                res_next.weight_c = coord_t'(wc_sum);
            end
        end
    end

    // control state: valids, skid flag, threshold
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
            thr_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                thr_reg <= cfg_data;
            end
            if (adv) begin
                vld_reg     <= {vld_reg[PIPE_DEPTH-2:0], s_valid};
                out_vld_reg <= vld_reg[PIPE_DEPTH-1];
            end
            priority if (adv && out_vld_reg && !m_ready) begin
                skid_vld_reg <= 1'b1;
            end else if (m_ready) begin
                skid_vld_reg <= 1'b0;
            end
        end
    end

    // output register and skid stage
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= res_next;
            if (out_vld_reg && !m_ready) begin
                skid_reg <= out_reg;
            end
        end
    end

    assign m_res          = skid_vld_reg ? skid_reg : out_reg;
    assign m_valid        = skid_vld_reg || out_vld_reg;
    assign m_weight_a     = m_res.weight_a;
    assign m_weight_b     = m_res.weight_b;
    assign m_weight_c     = m_res.weight_c;
    assign m_dropped_axis = m_res.axis;
    assign m_degenerate   = m_res.degenerate;

    `TBW_ASSERT_NXT(a_stall_holds, aclk, aresetn, skid_vld_reg && !m_ready, skid_vld_reg && $stable(out_vld_reg) && $stable(vld_reg))
    `TBW_ASSERT_IMP(a_deg_zero, aclk, aresetn, m_valid && m_degenerate, m_weight_a == '0 && m_weight_b == '0 && m_weight_c == '0)
    `TBW_ASSERT_NXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, vld_reg[0])

endmodule

// File: test/triangle_barycentric_weights_tb.sv
module triangle_barycentric_weights_tb
    import tbw_pkg::*;
;

    typedef logic signed [255:0] wide_t;
    typedef logic [11:0][COORD_WIDTH-1:0] tri_item_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [THR_WIDTH-1:0] cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    tri_item_t            s_item = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    coord_t               m_weight_a, m_weight_b, m_weight_c;
    logic [1:0]           m_dropped_axis;
    logic                 m_degenerate;

    tri_item_t            pending_q[$];
    result_t              weights_q[$];
    logic [THR_WIDTH-1:0] thr_shadow = '0;
    int                   mismatch_cnt = 0;
    int                   result_cnt = 0;
    int                   degen_cnt = 0;
    int                   cycle_cnt = 0;

    triangle_barycentric_weights dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_vertex_a_x(s_item[0]), .s_vertex_a_y(s_item[1]), .s_vertex_a_z(s_item[2]),
        .s_vertex_b_x(s_item[3]), .s_vertex_b_y(s_item[4]), .s_vertex_b_z(s_item[5]),
        .s_vertex_c_x(s_item[6]), .s_vertex_c_y(s_item[7]), .s_vertex_c_z(s_item[8]),
        .s_point_x(s_item[9]), .s_point_y(s_item[10]), .s_point_z(s_item[11]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_weight_a(m_weight_a), .m_weight_b(m_weight_b), .m_weight_c(m_weight_c),
        .m_dropped_axis(m_dropped_axis), .m_degenerate(m_degenerate)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Truncated quotient num * 2^FRAC_BITS / den, saturated to a coordinate
    function automatic longint scaled_quotient(wide_t num, wide_t den);
        logic  neg;
        wide_t q;
        neg = (num < 0) != (den < 0);
        if (num < 0) num = -num;
        if (den < 0) den = -den;
        q = (num <<< FRAC_BITS) / den;
        if (q >= 256'sd2147483648) return neg ? -64'sd2147483648 : 64'sd2147483647;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // Predict weights, dropped axis and degeneracy for one triangle item
    function automatic result_t barycentric_predict(tri_item_t it, logic [THR_WIDTH-1:0] thr);
        wide_t   va[12];
        wide_t   ab[3], cb[3], nrm[3], u[3], w[3];
        wide_t   pu, pw, d, l1, l2, tw, x;
        int      ax, k0, k1;
        logic    deg;
        longint  wa, wb, wc;
        result_t r;
        for (int i = 0; i < 12; i++) va[i] = $signed(it[i]);
        for (int j = 0; j < 3; j++) begin
            ab[j] = va[j] - va[3+j];
            cb[j] = va[6+j] - va[3+j];
        end
        nrm[0] = ab[1] * cb[2] - ab[2] * cb[1];
        nrm[1] = ab[2] * cb[0] - ab[0] * cb[2];
        nrm[2] = ab[0] * cb[1] - ab[1] * cb[0];
        for (int j = 0; j < 3; j++) if (nrm[j] < 0) nrm[j] = -nrm[j];
        // ties keep the lower axis
        ax = (nrm[1] > nrm[0]) ? 1 : 0;
        if (nrm[2] > nrm[ax]) ax = 2;
        k0 = (ax + 1) % 3;
        k1 = (ax + 2) % 3;
        for (int i = 0; i < 3; i++) begin
            u[i] = va[3*i+k0];
            w[i] = va[3*i+k1];
        end
        pu = va[9+k0];
        pw = va[9+k1];
        d  = (u[0] - u[1]) * (w[2] - w[1]) - (w[0] - w[1]) * (u[2] - u[1]);
        l1 = (u[2] - u[1]) * (u[2] - u[1]) + (w[2] - w[1]) * (w[2] - w[1]);
        l2 = (u[0] - u[2]) * (u[0] - u[2]) + (w[0] - w[2]) * (w[0] - w[2]);
        tw = '0;
        tw[THR_WIDTH-1:0] = thr;
        deg = (l1 <= tw) || (l2 <= tw) || (d * d <= tw * l1) || (d * d <= tw * l2);
        wa = 0;
        wb = 0;
        wc = 0;
        if (!deg) begin
            x  = (pu - u[1]) * (w[2] - w[1]) - (pw - w[1]) * (u[2] - u[1]);
            wa = scaled_quotient(x, d);
            x  = (pu - u[2]) * (w[0] - w[2]) - (pw - w[2]) * (u[0] - u[2]);
            wb = scaled_quotient(x, d);
            wc = (64'sd1 <<< FRAC_BITS) - wa - wb;
            if (wc > 64'sd2147483647) wc = 64'sd2147483647;
            if (wc < -64'sd2147483648) wc = -64'sd2147483648;
        end
        r.weight_a   = coord_t'(wa);
        r.weight_b   = coord_t'(wb);
        r.weight_c   = coord_t'(wc);
        r.axis       = (ax == 0) ? AXIS_X : (ax == 1) ? AXIS_Y : AXIS_Z;
        r.degenerate = deg;
        return r;
    endfunction

    function automatic logic idle_now();
        if (cycle_cnt >= 600 && cycle_cnt < 900) return 1'b0;
        return $urandom_range(0, 99) < 15;
    endfunction

    // Driver: hold the item until accepted, then advance from the pending queue
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) weights_q.push_back(barycentric_predict(s_item, thr_shadow));
            if (!s_valid || s_ready) begin
                if (pending_q.size() != 0 && !idle_now()) begin
                    s_item  <= pending_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        result_t exp_r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !idle_now();
            if (m_valid && m_ready) begin
                if (weights_q.size() == 0) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10) $display("unexpected result item at cycle %0d", cycle_cnt);
                end else begin
                    exp_r = weights_q.pop_front();
                    result_cnt <= result_cnt + 1;
                    if (exp_r.degenerate) degen_cnt <= degen_cnt + 1;
                    if (m_weight_a !== exp_r.weight_a || m_weight_b !== exp_r.weight_b ||
                        m_weight_c !== exp_r.weight_c || m_dropped_axis !== exp_r.axis ||
                        m_degenerate !== exp_r.degenerate) begin
                        mismatch_cnt <= mismatch_cnt + 1;
                        if (mismatch_cnt < 10)
                            $display("mismatch: exp wa=%0d wb=%0d wc=%0d ax=%0d dg=%0d, got wa=%0d wb=%0d wc=%0d ax=%0d dg=%0d",
                                     exp_r.weight_a, exp_r.weight_b, exp_r.weight_c, exp_r.axis,
                                     exp_r.degenerate, m_weight_a, m_weight_b, m_weight_c,
                                     m_dropped_axis, m_degenerate);
                    end
                end
            end
        end
    end

    function automatic coord_t near_coord(int span);
        return coord_t'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic tri_item_t build_item(coord_t a[3], coord_t b[3], coord_t c[3], coord_t p[3]);
        tri_item_t it;
        for (int j = 0; j < 3; j++) begin
            it[j] = a[j];
            it[3+j] = b[j];
            it[6+j] = c[j];
            it[9+j] = p[j];
        end
        return it;
    endfunction

    // Random item: mostly well-formed small triangles, some full-range, collinear or repeated
    function automatic tri_item_t random_item();
        coord_t    a[3], b[3], c[3], p[3];
        int        kind, span;
        tri_item_t it;
        kind = $urandom_range(0, 9);
        span = 1 << $urandom_range(4, 24);
        for (int j = 0; j < 3; j++) begin
            a[j] = near_coord(span);
            b[j] = near_coord(span);
            c[j] = near_coord(span);
            p[j] = near_coord(span);
        end
        if (kind == 0) begin
            for (int i = 0; i < 12; i++) it[i] = $urandom;
            return it;
        end
        if (kind == 1) begin
            for (int j = 0; j < 3; j++) c[j] = a[j] + 2 * (b[j] - a[j]);
        end else if (kind == 2) begin
            b = a;
        end else if (kind == 3) begin
            // pin the x coordinates of a and b and zero one coordinate of c
            a[kind % 3] = 0;
            b[kind % 3] = 1;
            c[$urandom_range(0, 2)] = a[0];
        end
        return build_item(a, b, c, p);
    endfunction

    task automatic write_threshold(logic [THR_WIDTH-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        thr_shadow <= value;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || weights_q.size() != 0 || s_valid) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic add_directed();
        coord_t    a[3], b[3], c[3], p[3];
        tri_item_t it;
        pending_q.push_back('0);
        for (int i = 0; i < 12; i++) it[i] = 32'h7fffffff;
        pending_q.push_back(it);
        for (int i = 0; i < 12; i++) it[i] = 32'h80000000;
        pending_q.push_back(it);
        for (int i = 0; i < 12; i++) it[i] = (i % 2) ? 32'h80000000 : 32'h7fffffff;
        pending_q.push_back(it);
        for (int i = 0; i < 12; i++) it[i] = ((i / 3) % 2) ? 32'h80000000 : 32'h7fffffff;
        pending_q.push_back(it);
        // unit triangles in each plane, point inside, on a vertex and outside
        for (int ax = 0; ax < 3; ax++) begin
            a = '{0, 0, 0}; b = '{0, 0, 0}; c = '{0, 0, 0};
            b[(ax+1)%3] = 32'h10000;
            c[(ax+2)%3] = 32'h10000;
            p = '{32'h4000, 32'h4000, 32'h4000};
            pending_q.push_back(build_item(a, b, c, p));
            pending_q.push_back(build_item(a, b, c, b));
            p = '{-32'sh30000, 32'h50000, -32'sh20000};
            pending_q.push_back(build_item(a, b, c, p));
        end
        // tiny triangle with a far point saturates the weights
        a = '{0, 0, 0}; b = '{1, 0, 0}; c = '{0, 1, 0};
        p = '{32'h7fffffff, 32'h80000000, 0};
        pending_q.push_back(build_item(a, b, c, p));
        p = '{32'h80000000, 32'h80000000, 0};
        pending_q.push_back(build_item(a, b, c, p));
        // collinear and repeated vertices
        a = '{1, 2, 3}; b = '{3, 6, 9}; c = '{5, 10, 15}; p = '{7, 7, 7};
        pending_q.push_back(build_item(a, b, c, p));
        pending_q.push_back(build_item(a, a, c, p));
        // equal normal components on all three axes: tie keeps x
        a = '{0, 0, 0}; b = '{32'h10000, 0, 32'h10000}; c = '{0, 32'h10000, 32'h10000};
        pending_q.push_back(build_item(a, b, c, p));
        // equal components on all three axes again: tie keeps x
        a = '{0, 0, 0}; b = '{32'h10000, 32'h10000, 0}; c = '{32'h10000, 0, 32'h10000};
        pending_q.push_back(build_item(a, b, c, p));
    endtask

    // Stimulus: phases with different thresholds, drained between writes
    initial begin
        logic [THR_WIDTH-1:0] thr_set[6];
        thr_set[0] = '0;
        thr_set[1] = {THR_WIDTH{1'b1}};
        thr_set[2] = 40'd1 << 20;
        thr_set[3] = THR_WIDTH'({$urandom, $urandom});
        thr_set[4] = 40'd1;
        thr_set[5] = 40'd1 << 36;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int ph = 0; ph < 6; ph++) begin
            write_threshold(thr_set[ph]);
            add_directed();
            for (int k = 0; k < 150; k++) begin
                pending_q.push_back(random_item());
                // hold the sender once mid-phase until everything has come back
                if (k == 75 && ph == 2) begin
                    while (pending_q.size() != 0 || weights_q.size() != 0 || s_valid)
                        @(posedge aclk);
                end
            end
            drain();
        end
        $display("covered %0d result items (%0d degenerate) over six threshold settings",
                 result_cnt, degen_cnt);
        if (mismatch_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d items outstanding", weights_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
